// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SMX_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define SMX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/smx_pkg.sv -----
// Package for the stack machine execute unit: widths, opcodes, payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;
  localparam int StackDepth = 64;
  localparam int NumVars    = 16;
  localparam int IpBits     = 16;
  localparam int SpW        = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int VarW       = $clog2(NumVars);
  localparam int ValW       = 33;

  localparam logic [4:0] OP_PUSH = 5'd0,  OP_PUSH_BOOL = 5'd1, OP_LOAD = 5'd2,
                         OP_STORE = 5'd3, OP_ADD = 5'd4, OP_SUB = 5'd5,
                         OP_MUL = 5'd6,   OP_DIV = 5'd7, OP_EQ = 5'd8,
                         OP_LESS = 5'd9,  OP_GREATER = 5'd10, OP_PRINT = 5'd11,
                         OP_INPUT = 5'd12, OP_JUMP = 5'd13, OP_JIF = 5'd14,
                         OP_POP = 5'd15,  OP_HALT = 5'd16;

  localparam logic [2:0] ERR_NONE = 3'd0, ERR_UNDER = 3'd1, ERR_UNDEF = 3'd2,
                         ERR_DIV0 = 3'd3, ERR_BADOP = 3'd4, ERR_OVER = 3'd5;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] operand;
    logic [3:0]         var_index;
    logic signed [31:0] console_value;
  } in_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               print_is_bool;
    logic               halted;
    logic [2:0]         error_code;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input beat
    logic rd_pop;      // issue the stack read of the top
    logic rd_sec;      // second read cycle
    logic div_start;
    logic commit;      // decide and update state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic is_div;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/smx_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module smx_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/smx_div.sv -----
// Iterative 32-bit signed divider, truncating toward zero, one bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module smx_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             busy_o,
  output logic [31:0]      q_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [32:0] trial;

  assign busy_o = (cnt_q != 6'd0);
  assign q_o    = neg_q ? (~quo_q + 32'd1) : quo_q;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q; neg_d = neg_q;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[31] ? (~a_i + 32'd1) : a_i;
      den_d = b_i[31] ? (~b_i + 32'd1) : b_i;
      neg_d = a_i[31] ^ b_i[31];
      cnt_d = 6'd32;
    end else if (busy_o) begin
      if (!trial[32]) rem_d = trial[31:0];
      else rem_d = {rem_q[30:0], quo_q[31]};
      quo_d = {quo_q[30:0], ~trial[32]};
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule
`default_nettype wire

// ----- design/smx_datapath.sv -----
// Datapath: stack RAM, variable store, pointer, error state, ALU and result register.
// Depends on smx_pkg, smx_ram, smx_div.
`timescale 1ns / 1ps
`default_nettype none
module smx_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire smx_pkg::in_t  in_i,
  input  wire smx_pkg::cmd_t cmd_i,
  output smx_pkg::sts_t      sts_o,
  output smx_pkg::out_t      res_o
);
  smx_pkg::in_t in_q;
  logic [smx_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [smx_pkg::IpBits-1:0] ip_q, ip_d;
  logic halt_q, halt_d;
  logic [2:0] err_q, err_d;
  logic [smx_pkg::NumVars-1:0] def_q, def_d;
  logic [smx_pkg::ValW-1:0] vb_q, rdata, var_rd;
  logic [smx_pkg::SpW-1:0] raddr, waddr;
  logic [smx_pkg::VarW-1:0] vslot;
  logic we, vwe;
  logic [smx_pkg::ValW-1:0] wval;
  logic [31:0] prod_q, quo, a, b;
  logic [1:0] need;
  logic grow, slot_ok;
  smx_pkg::out_t res_d;
  logic [2:0] e;

  assign vslot = in_q.var_index[smx_pkg::VarW-1:0];
  assign slot_ok = ({28'd0, in_q.var_index} < 32'(smx_pkg::NumVars));

  smx_ram #(.Width(smx_pkg::ValW), .Depth(smx_pkg::StackDepth)) u_stack (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wval), .raddr_i(raddr), .rdata_o(rdata));
  smx_ram #(.Width(smx_pkg::ValW), .Depth(smx_pkg::NumVars)) u_vars (
    .clk_i, .we_i(vwe), .waddr_i(vslot), .wdata_i(vb_q), .raddr_i(vslot), .rdata_o(var_rd));

  // rd_pop reads top; otherwise second stays addressed through commit
  // (vb_q latches top on rd_sec)
  assign raddr = cmd_i.rd_pop ? smx_pkg::SpW'(cnt_q - 1) : smx_pkg::SpW'(cnt_q - 2);
  assign a = rdata[31:0];
  assign b = vb_q[31:0];

  smx_div u_div (.clk_i, .rst_ni, .start_i(cmd_i.div_start), .a_i(a), .b_i(b),
    .busy_o(sts_o.div_busy), .q_o(quo));
  assign sts_o.is_div = (in_q.op == smx_pkg::OP_DIV);

  always_comb begin
    need = 2'd0; grow = 1'b0; e = smx_pkg::ERR_NONE;
    unique case (in_q.op)
      smx_pkg::OP_PUSH, smx_pkg::OP_PUSH_BOOL, smx_pkg::OP_LOAD,
      smx_pkg::OP_INPUT: grow = 1'b1;
      smx_pkg::OP_STORE, smx_pkg::OP_PRINT, smx_pkg::OP_JIF,
      smx_pkg::OP_POP: need = 2'd1;
      smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV,
      smx_pkg::OP_EQ, smx_pkg::OP_LESS, smx_pkg::OP_GREATER: begin
        need = 2'd2; grow = 1'b1;
      end
      smx_pkg::OP_JUMP, smx_pkg::OP_HALT: ;
      default: e = smx_pkg::ERR_BADOP;
    endcase
    if (e == smx_pkg::ERR_NONE && cnt_q < smx_pkg::CntW'(need)) e = smx_pkg::ERR_UNDER;
    if (e == smx_pkg::ERR_NONE && in_q.op == smx_pkg::OP_LOAD && !(slot_ok && def_q[vslot]))
      e = smx_pkg::ERR_UNDEF;
    if (e == smx_pkg::ERR_NONE && in_q.op == smx_pkg::OP_DIV && b == 32'd0)
      e = smx_pkg::ERR_DIV0;
    if (e == smx_pkg::ERR_NONE && grow && need == 2'd0 &&
        cnt_q == smx_pkg::CntW'(smx_pkg::StackDepth)) e = smx_pkg::ERR_OVER;
  end

  always_comb begin
    cnt_d = cnt_q; ip_d = ip_q; halt_d = halt_q; err_d = err_q; def_d = def_q;
    we = 1'b0; vwe = 1'b0; wval = '0;
    waddr = smx_pkg::SpW'(cnt_q - smx_pkg::CntW'(need));
    res_d = res_o;
    if (cmd_i.commit) begin
      res_d.print_valid = 1'b0; res_d.print_value = '0; res_d.print_is_bool = 1'b0;
      if (!halt_q) begin
        if (e != smx_pkg::ERR_NONE) begin
          err_d = e; halt_d = 1'b1;
        end else begin
          ip_d = ip_q + 1'b1;
          case (in_q.op)
            smx_pkg::OP_PUSH: wval = {1'b0, in_q.operand};
            smx_pkg::OP_PUSH_BOOL: wval = {1'b1, 31'd0, in_q.operand == 32'sd1};
            smx_pkg::OP_LOAD: wval = var_rd;
            smx_pkg::OP_STORE: if (slot_ok) begin
              vwe = 1'b1; def_d[vslot] = 1'b1;
            end
            smx_pkg::OP_ADD: wval = {1'b0, a + b};
            smx_pkg::OP_SUB: wval = {1'b0, a - b};
            smx_pkg::OP_MUL: wval = {1'b0, prod_q};
            smx_pkg::OP_DIV: wval = {1'b0, quo};
            smx_pkg::OP_EQ: wval = {1'b1, 31'd0, rdata == vb_q};
            smx_pkg::OP_LESS: wval = {1'b1, 31'd0, $signed(a) < $signed(b)};
            smx_pkg::OP_GREATER: wval = {1'b1, 31'd0, $signed(a) > $signed(b)};
            smx_pkg::OP_PRINT: begin
              res_d.print_valid = 1'b1; res_d.print_value = vb_q[31:0];
              res_d.print_is_bool = vb_q[32];
            end
            smx_pkg::OP_INPUT: wval = {1'b0, in_q.console_value};
            smx_pkg::OP_JUMP: ip_d = in_q.operand[smx_pkg::IpBits-1:0];
            smx_pkg::OP_JIF: if (vb_q[31:0] == 32'd0) ip_d = in_q.operand[smx_pkg::IpBits-1:0];
            smx_pkg::OP_HALT: begin
              halt_d = 1'b1; ip_d = ip_q;
            end
            default: ;
          endcase
          we = grow;
          cnt_d = cnt_q - smx_pkg::CntW'(need) + smx_pkg::CntW'(grow);
        end
      end
      res_d.next_ip = 16'(ip_d);
      res_d.halted = halt_d;
      res_d.error_code = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ip_q <= '0; halt_q <= 1'b0; err_q <= '0; def_q <= '0;
    end else begin
      cnt_q <= cnt_d; ip_q <= ip_d; halt_q <= halt_d; err_q <= err_d; def_q <= def_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_i;
    if (cmd_i.rd_sec) vb_q <= rdata;
    prod_q <= a * b;
    res_o <= res_d;
  end
endmodule
`default_nettype wire

// ----- design/smx_ctrl.sv -----
// Controller: sequences capture, stack reads, divide wait, commit and output beat.
// Depends on smx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smx_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire smx_pkg::sts_t sts_i,
  output smx_pkg::cmd_t      cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2, S_EXE = 3'd3,
                         S_DIV = 3'd4, S_WAIT = 3'd5, S_CMT = 3'd6;
  logic [2:0] st_q, st_d;
  logic ov_q, ov_d;
  logic free;

  assign free = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q; cmd_o = '0;
    ov_d = ov_q && !out_ready_i;
    unique case (st_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load_in = 1'b1; st_d = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_pop = 1'b1; st_d = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd_sec = 1'b1; st_d = S_EXE;
      end
      S_EXE: if (sts_i.is_div) begin
        cmd_o.div_start = 1'b1; st_d = S_DIV;
      end else st_d = S_CMT;
      S_DIV: st_d = S_WAIT;
      S_WAIT: if (!sts_i.div_busy) st_d = S_CMT;
      S_CMT: if (free) begin
        cmd_o.commit = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/stack_machine_execute_unit_top.sv -----
// Top level of the stack machine execute unit.
// Depends on smx_pkg, smx_ctrl, smx_datapath.
//
// One instruction enters on the in channel (valid/ready, in_data_i), one
// result beat leaves on the out channel (valid/ready, out_data_o).
// The result register is loaded after the states S_RD1, S_RD2 (two reads of
// the stack RAM), S_EXE (execute) and S_CMT (commit); DIV adds S_DIV and
// S_WAIT for the one-bit-per-cycle divider. The stack RAM's single read
// port puts the two reads in separate states. A new instruction is accepted
// right after commit, while the prior result may still sit in the output
// register.
// If the receiver stalls, commit waits until the output register is free.
// Reset empties the stack, clears variable defined bits, pointer, halt flag
// and error code. No clearing pass is needed.
// After HALT or any error every instruction is ignored and returns the
// frozen pointer with halted set.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_unit_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire smx_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output smx_pkg::out_t      out_data_o
);
  smx_pkg::cmd_t cmd;
  smx_pkg::sts_t sts;

  smx_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o,
    .out_ready_i, .sts_i(sts), .cmd_o(cmd));
  smx_datapath u_dp (.clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .res_o(out_data_o));
endmodule
`default_nettype wire

// ----- design/smx_checker.sv -----
// Port-level checker for the stack machine execute unit, bound to the top.
// Depends on smx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module smx_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire smx_pkg::out_t out_data_o
);
  `SMX_ASSERT_IMPL(a_err_halts, clk_i, rst_ni,
    out_valid_o && out_data_o.error_code != smx_pkg::ERR_NONE, out_data_o.halted)
  `SMX_ASSERT_IMPL(a_no_print_halt, clk_i, rst_ni,
    out_valid_o && out_data_o.print_valid, !out_data_o.halted)
  `SMX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `SMX_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o, !in_ready_o)
endmodule
bind stack_machine_execute_unit_top smx_checker u_chk (.clk_i, .rst_ni, .in_valid_i,
  .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o);
`default_nettype wire
